// File: hw/rtl/hssc_pkg.sv
// Shared types for the heap segment sweep and coalesce unit.
// Holds the input word, result word and the command passed from front to back.
// No dependencies.
package hssc_pkg;

    // One block header as it arrives from heap memory.
    typedef struct packed {
        logic        segment_start;
        logic [16:0] payload_size;
        logic        is_live;
    } t_in;

    // One write-back and free-list word per header.
    typedef struct packed {
        logic        block_free;
        logic        run_closed;
        logic [15:0] run_offset;
        logic [16:0] run_payload;
        logic        segment_done;
        logic        overrun;
        logic [16:0] free_total;
        logic        ignored;
    } t_out;

    // How the front part classified a header.
    typedef enum logic [1:0] {
        K_BLOCK     = 2'd0,
        K_OVERRUN   = 2'd1,
        K_EXHAUSTED = 2'd2,
        K_IGNORED   = 2'd3
    } t_kind;

    // Classified header handed from the front part to the back part.
    typedef struct packed {
        logic        seg_start;
        t_kind       kind;
        logic        live;
        logic        last;
        logic [15:0] head;
        logic [16:0] size;
    } t_cmd;

endpackage

// File: hw/rtl/hssc_fifo.sv
// Small register queue used between the front and back parts and at the output.
// Generic width and depth; no package dependencies.
module hssc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update; pointers wrap at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/hssc_front.sv
// Front part: walks the byte cursor and classifies each accepted header.
// Depends on hssc_pkg for the input word and command types.
module hssc_front #(
    parameter int SEGMENT_BYTES = 65536,
    parameter int HEADER_BYTES  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  hssc_pkg::t_in  i_item,
    output hssc_pkg::t_cmd o_cmd
);

    import hssc_pkg::*;

    localparam int CW = $clog2(SEGMENT_BYTES + 1);
    localparam int EW = ((CW > 17) ? CW : 17) + 2;

    logic [CW-1:0] r_cursor, n_cursor;
    logic          r_walk_done, n_walk_done;
    logic [EW-1:0] cur;
    logic [EW-1:0] hdr_end;
    logic [EW-1:0] blk_end;
    logic [EW-1:0] next_hdr_end;
    logic          done;

    // A segment start clears the walk before this header is looked at.
    always_comb begin
        cur          = i_item.segment_start ? '0 : {{(EW - CW){1'b0}}, r_cursor};
        done         = !i_item.segment_start && r_walk_done;
        hdr_end      = cur + EW'(HEADER_BYTES);
        blk_end      = hdr_end + EW'(i_item.payload_size);
        next_hdr_end = blk_end + EW'(HEADER_BYTES);
    end

    // Classification and next cursor.
    always_comb begin
        o_cmd.seg_start = i_item.segment_start;
        o_cmd.live      = i_item.is_live;
        o_cmd.head      = cur[15:0];
        o_cmd.size      = i_item.payload_size;
        o_cmd.last      = 1'b0;
        n_cursor        = cur[CW-1:0];
        n_walk_done     = 1'b1;
        priority if (done) begin
            o_cmd.kind = K_IGNORED;
            n_cursor   = r_cursor;
        end else if (hdr_end > EW'(SEGMENT_BYTES)) begin
            o_cmd.kind = K_EXHAUSTED;
        end else if (blk_end > EW'(SEGMENT_BYTES)) begin
            o_cmd.kind = K_OVERRUN;
        end else begin
            o_cmd.kind  = K_BLOCK;
            o_cmd.last  = (next_hdr_end > EW'(SEGMENT_BYTES));
            n_cursor    = blk_end[CW-1:0];
            n_walk_done = o_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_walk_done <= 1'b0;
        end else if (i_accept) begin
            r_cursor    <= n_cursor;
            r_walk_done <= n_walk_done;
        end
    end

endmodule

// File: hw/rtl/hssc_back.sv
// Back part: keeps the open free run and the free total, builds each result word.
// Depends on hssc_pkg for the command and result types.
module hssc_back #(
    parameter int HEADER_BYTES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  hssc_pkg::t_cmd i_cmd,
    output hssc_pkg::t_out o_result
);

    import hssc_pkg::*;

    logic        r_run_open, n_run_open;
    logic [15:0] r_run_head, n_run_head;
    logic [16:0] r_run_size, n_run_size;
    logic [16:0] r_free_sum, n_free_sum;
    logic        run_open;
    logic [16:0] free_sum;
    logic [16:0] ext_size;
    logic [15:0] ext_head;
    logic        do_close;
    logic [15:0] close_head;
    logic [16:0] close_size;
    logic [16:0] closed_sum;

    // A segment start sees an empty run and a zero total.
    always_comb begin
        run_open = !i_cmd.seg_start && r_run_open;
        free_sum = i_cmd.seg_start ? '0 : r_free_sum;
        ext_size = run_open ? (r_run_size + 17'(HEADER_BYTES) + i_cmd.size) : i_cmd.size;
        ext_head = run_open ? r_run_head : i_cmd.head;
    end

    // Decide which run closes with this word and how the run state moves.
    always_comb begin
        do_close   = 1'b0;
        close_head = r_run_head;
        close_size = r_run_size;
        n_run_open = run_open;
        n_run_head = r_run_head;
        n_run_size = r_run_size;
        unique case (i_cmd.kind)
            K_BLOCK: begin
                if (i_cmd.live) begin
                    do_close   = run_open;
                    n_run_open = 1'b0;
                end else begin
                    close_head = ext_head;
                    close_size = ext_size;
                    do_close   = i_cmd.last;
                    n_run_open = !i_cmd.last;
                    n_run_head = ext_head;
                    n_run_size = ext_size;
                end
            end
            K_OVERRUN, K_EXHAUSTED: begin
                do_close   = run_open;
                n_run_open = 1'b0;
            end
            default: begin
                n_run_open = r_run_open;
            end
        endcase
        closed_sum = free_sum + close_size + 17'(HEADER_BYTES);
        n_free_sum = do_close ? closed_sum : free_sum;
    end

    // Result word for this header.
    always_comb begin
        o_result.block_free   = (i_cmd.kind == K_BLOCK) && !i_cmd.live;
        o_result.run_closed   = do_close;
        o_result.run_offset   = do_close ? close_head : '0;
        o_result.run_payload  = do_close ? close_size : '0;
        o_result.segment_done = (i_cmd.kind != K_BLOCK) || i_cmd.last;
        o_result.overrun      = (i_cmd.kind == K_OVERRUN);
        o_result.free_total   = n_free_sum;
        o_result.ignored      = (i_cmd.kind == K_IGNORED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
            r_run_head <= '0;
            r_run_size <= '0;
            r_free_sum <= '0;
        end else if (i_fire) begin
            r_run_open <= n_run_open;
            r_run_head <= n_run_head;
            r_run_size <= n_run_size;
            r_free_sum <= n_free_sum;
        end
    end

endmodule

// File: hw/rtl/heap_segment_sweep_coalesce_unit.sv
// Sweep phase of a mark-sweep collector with free-block coalescing, one header
// per cycle while full is low. An accepted header is classified by the front part
// in the cycle it is pushed (adds and compares against the byte cursor), waits
// in a two-word command queue, and is carried out by the back part (run merge and
// free total, one add chain) into a two-word result queue. Sustained rate is one
// word per cycle on both sides while results are popped; a header's command is
// registered in the command queue and its result word in the result queue. Full
// rises only when the back part is held up by a result that is not popped.
// Depends on hssc_pkg, hssc_fifo, hssc_front and hssc_back.
module heap_segment_sweep_coalesce_unit #(
    parameter int SEGMENT_BYTES = 65536,
    parameter int HEADER_BYTES  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  hssc_pkg::t_in  i_item,
    input  logic           pop,
    output logic           empty,
    output hssc_pkg::t_out o_result
);

    import hssc_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    logic  in_accept;
    t_cmd  front_cmd;
    t_cmd  queue_cmd;
    logic  cmd_empty;
    logic  res_full;
    logic  back_fire;
    t_out  back_result;

    assign in_accept = push && !full;
    assign back_fire = !cmd_empty && !res_full;

    // Front part: cursor walk and classification.
    hssc_front #(
        .SEGMENT_BYTES(SEGMENT_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_item  (i_item),
        .o_cmd   (front_cmd)
    );

    // Command queue between the two parts.
    hssc_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_accept),
        .i_data (front_cmd),
        .o_full (full),
        .i_pop  (back_fire),
        .o_data (queue_cmd),
        .o_empty(cmd_empty)
    );

    // Back part: run coalescing and free total.
    hssc_back #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (back_fire),
        .i_cmd   (queue_cmd),
        .o_result(back_result)
    );

    // Result queue toward the consumer.
    hssc_fifo #(
        .WIDTH($bits(t_out)),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (back_fire),
        .i_data (back_result),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty)
    );

    // An ignored word always reports the walk as finished.
    a_ignored_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.ignored) |-> (o_result.segment_done && !o_result.block_free))
        else $error("ignored word without segment_done");

    // An overrun ends the walk and leaves the header in use.
    a_overrun_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.overrun) |-> (o_result.segment_done && !o_result.block_free))
        else $error("overrun word inconsistent");

    // Run fields are zero unless a run closes.
    a_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.run_closed) |->
            (o_result.run_offset == 16'd0 && o_result.run_payload == 17'd0))
        else $error("run fields set without run_closed");

    // A word moved by the back part is waiting in the result queue next cycle.
    a_back_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_fire |=> !empty)
        else $error("back part word lost");

endmodule
